FILE: hdl/stream_byte_reassembler_unit_assert.svh
// ----------------------------------------------------------------------------
// Stream byte reassembler assertion macros
// Short forms for the concurrent checks used in the reassembler RTL.
// ----------------------------------------------------------------------------
`ifndef STREAM_BYTE_REASSEMBLER_UNIT_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define SBR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SBR_ASSERT_IMPLY_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants of the stream byte reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbr_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;
    localparam int ROOM_W      = 11;

    // kind codes carried on s_tuser
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_DRAIN   = 1'b1;

    // classified item handed from the front to the back
    typedef struct packed {
        logic              is_seg;
        logic [63:0]       idx;
        logic [7:0]        data;
        logic              eos;
        logic              room_nz;
        logic [ROOM_W-1:0] window;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Input side: takes items from the slave stream, decodes the fields and
// clamps the room to the store capacity, then pushes into the item queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbr_front #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [sbr_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         s_tlast,
    input  wire logic                         clearing,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output sbr_pkg::item_t                    push_item
);

    localparam logic [16:0] CAP17 = 17'(CAPACITY);

    logic [sbr_pkg::ROOM_W-1:0] room;

    assign room = s_tdata[82:72];

    // hold off input while the store is being swept after reset
    assign s_tready   = push_ready && !clearing;
    assign push_valid = s_tvalid && !clearing;

    always_comb begin
        push_item.is_seg  = (s_tuser == sbr_pkg::KIND_SEGMENT);
        push_item.idx     = s_tdata[63:0];
        push_item.data    = s_tdata[71:64];
        push_item.eos     = s_tlast;
        push_item.room_nz = (room != '0);
        if ({6'b0, room} > CAP17) begin
            push_item.window = CAP17[10:0];
        end else begin
            push_item.window = room;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sbr_fifo.sv
// ----------------------------------------------------------------------------
// sbr_fifo
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbr_fifo (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire sbr_pkg::item_t in_item,
    output logic         out_valid,
    input  wire logic    out_pop,
    output sbr_pkg::item_t out_item
);

    sbr_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sbr_back.sv
// ----------------------------------------------------------------------------
// sbr_back
// Reassembly engine: window check, ring store with valid bits, head
// delivery, end tracking and the result register of the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stream_byte_reassembler_unit_assert.svh"

module sbr_back #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire sbr_pkg::item_t                q_item,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sbr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int PW  = $clog2(CAPACITY + 1);
    localparam int PXW = PW + 11;
    localparam logic [AW:0]   CAP_W   = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SL = AW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CLASS,
        S_ADDR,
        S_WRITE,
        S_CLOSE1,
        S_DELIV,
        S_CLOSE2,
        S_EMIT
    } state_t;

    // ring store: bit 8 is the valid flag, bits 7:0 the byte
    logic [8:0] slot_mem [CAPACITY];
    logic [8:0] rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [8:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    state_t         state_reg,     state_next;
    logic [AW-1:0]  clr_cnt_reg,   clr_cnt_next;
    sbr_pkg::item_t item_reg,      item_next;
    logic [AW-1:0]  diff_lo_reg,   diff_lo_next;
    logic           accept_reg,    accept_next;
    logic [AW-1:0]  slot_reg,      slot_next;
    logic [63:0]    head_reg,      head_next;
    logic [AW-1:0]  head_slot_reg, head_slot_next;
    logic [PW-1:0]  pending_reg,   pending_next;
    logic           end_known_reg, end_known_next;
    logic [63:0]    end_index_reg, end_index_next;
    logic           closed_reg,    closed_next;
    logic           present_reg,   present_next;
    logic [7:0]     dbyte_reg,     dbyte_next;
    logic           m_valid_reg,   m_valid_next;
    logic           m_present_reg, m_present_next;
    logic [7:0]     m_byte_reg,    m_byte_next;
    logic [10:0]    m_pending_reg, m_pending_next;
    logic           m_closed_reg,  m_closed_next;

    logic [64:0]    diff;
    logic           in_win;
    logic [AW:0]    slot_sum;
    logic [AW-1:0]  slot_calc;
    logic           deliver;
    logic [PXW-1:0] pend_ext;

    assign clearing = (state_reg == S_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_present_reg;
    assign m_tdata  = {4'b0, m_closed_reg, m_pending_reg, m_byte_reg};

    assign diff      = {1'b0, item_reg.idx} - {1'b0, head_reg};
    assign in_win    = !diff[64] && (diff[63:0] < {53'b0, item_reg.window});
    assign slot_sum  = {1'b0, head_slot_reg} + {1'b0, diff_lo_reg};
    assign slot_calc = (slot_sum >= CAP_W) ? AW'(slot_sum - CAP_W) : slot_sum[AW-1:0];
    assign deliver   = !closed_reg && item_reg.room_nz && rd_reg[8];
    assign pend_ext  = PXW'(pending_reg);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        diff_lo_next   = diff_lo_reg;
        accept_next    = accept_reg;
        slot_next      = slot_reg;
        head_next      = head_reg;
        head_slot_next = head_slot_reg;
        pending_next   = pending_reg;
        end_known_next = end_known_reg;
        end_index_next = end_index_reg;
        closed_next    = closed_reg;
        present_next   = present_reg;
        dbyte_next     = dbyte_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_present_next = m_present_reg;
        m_byte_next    = m_byte_reg;
        m_pending_next = m_pending_reg;
        m_closed_next  = m_closed_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = slot_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_SL) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    item_next  = q_item;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                // window check against the head
                accept_next  = item_reg.is_seg && !closed_reg && in_win;
                diff_lo_next = diff[AW-1:0];
                state_next   = S_ADDR;
            end
            S_ADDR: begin
                slot_next = slot_calc;
                mem_re    = 1'b1;
                mem_raddr = slot_calc;
                // record the end mark even when the byte is dropped
                if (item_reg.is_seg && !closed_reg && item_reg.eos) begin
                    end_known_next = 1'b1;
                    end_index_next = (&item_reg.idx) ? item_reg.idx
                                                     : item_reg.idx + 64'd1;
                end
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (accept_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_reg;
                    mem_wdata = {1'b1, item_reg.data};
                    if (!rd_reg[8]) begin
                        pending_next = pending_reg + PW'(1);
                    end
                end
                state_next = S_CLOSE1;
            end
            S_CLOSE1: begin
                if (end_known_reg && (head_reg >= end_index_reg)) begin
                    closed_next = 1'b1;
                end
                mem_re     = 1'b1;
                mem_raddr  = head_slot_reg;
                state_next = S_DELIV;
            end
            S_DELIV: begin
                present_next = deliver;
                dbyte_next   = deliver ? rd_reg[7:0] : 8'd0;
                if (deliver) begin
                    mem_we    = 1'b1;
                    mem_waddr = head_slot_reg;
                    mem_wdata = {1'b0, rd_reg[7:0]};
                    if (pending_reg != '0) begin
                        pending_next = pending_reg - PW'(1);
                    end
                    head_next      = head_reg + 64'd1;
                    head_slot_next = (head_slot_reg == LAST_SL) ? '0
                                                                : head_slot_reg + AW'(1);
                end
                state_next = S_CLOSE2;
            end
            S_CLOSE2: begin
                if (end_known_reg && (head_reg >= end_index_reg)) begin
                    closed_next = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_present_next = present_reg;
                    m_byte_next    = dbyte_reg;
                    m_pending_next = pend_ext[10:0];
                    m_closed_next  = closed_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            head_slot_reg <= '0;
            pending_reg   <= '0;
            end_known_reg <= 1'b0;
            end_index_reg <= '0;
            closed_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            item_reg      <= item_next;
            diff_lo_reg   <= diff_lo_next;
            accept_reg    <= accept_next;
            slot_reg      <= slot_next;
            head_reg      <= head_next;
            head_slot_reg <= head_slot_next;
            pending_reg   <= pending_next;
            end_known_reg <= end_known_next;
            end_index_reg <= end_index_next;
            closed_reg    <= closed_next;
            present_reg   <= present_next;
            dbyte_reg     <= dbyte_next;
            m_valid_reg   <= m_valid_next;
            m_present_reg <= m_present_next;
            m_byte_reg    <= m_byte_next;
            m_pending_reg <= m_pending_next;
            m_closed_reg  <= m_closed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_reg <= slot_mem[mem_raddr];
        end
    end

    `SBR_ASSERT_ALWAYS(a_pending_bound, aclk, aresetn, pending_reg <= PW'(CAPACITY), "pending above capacity")
    `SBR_ASSERT_ALWAYS(a_head_slot_bound, aclk, aresetn, head_slot_reg <= LAST_SL, "head slot out of range")
    `SBR_ASSERT_IMPLY_NEXT(a_closed_sticky, aclk, aresetn, closed_reg, closed_reg, "closed flag dropped")
    `SBR_ASSERT_IMPLY_NEXT(a_head_advance, aclk, aresetn, (state_reg == S_DELIV) && deliver, head_reg == $past(head_reg) + 64'd1, "head did not advance on delivery")
    `SBR_ASSERT_IMPLY(a_result_from_emit, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_EMIT, "result loaded outside emit")

endmodule

`default_nettype wire

FILE: hdl/stream_byte_reassembler_unit.sv
// Flow: each item passes the item queue, then the back-end sequence of window check,
//   store read, store write, head read and close checks, before the result is valid.
// Items: the back end works on one item at a time; the ring store is visited twice
//   per item, and a stalled m_tready holds the back end until the result register frees.
// Reset: synchronous, active low; after reset a sweep over all CAPACITY slots
//   clears the valid bits of the store while s_tready stays low.
// ----------------------------------------------------------------------------
// stream_byte_reassembler_unit
// Rebuilds an in-order byte stream from indexed bytes that arrive out of order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stream_byte_reassembler_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // stream_index[63:0], data_byte[71:64], downstream_room[82:72], zero fill
    input  wire logic [sbr_pkg::IN_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                           s_tuser,
    // end_of_stream
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_byte[7:0], pending_count[18:8], stream_closed[19], zero fill
    output logic [sbr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // byte_present
    output logic                                m_tuser
);

    logic           clearing;
    logic           push_valid;
    logic           push_ready;
    sbr_pkg::item_t push_item;
    logic           q_valid;
    logic           q_pop;
    sbr_pkg::item_t q_item;

    sbr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sbr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    sbr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
